// File: rtl/core/utf8_stream_decoder_assert.svh
// Assertion macros used by the top level of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UTF8SD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/utf8sd_pkg.sv
// Shared types, codes and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned CpWidth    = 21;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_REPORTED = 2'd1,
      STATUS_REPLACED = 2'd2
   } status_type;

   // Error handling modes; the unused fourth code drops like MODE_DROP
   typedef enum logic [1:0] {
      MODE_REPORT  = 2'd0,
      MODE_REPLACE = 2'd1,
      MODE_DROP    = 2'd2
   } err_mode_type;

   localparam logic [CpWidth-1:0] REPLACEMENT_CP = 21'h00FFFD;

   // One decoded event: a code point or a malformed sequence
   typedef struct packed {
      logic               bad;
      logic [CpWidth-1:0] cp;
   } event_type;

   // Front end to queue
   typedef struct packed {
      logic      push;
      event_type ev;
   } front_out_type;

   // Queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_tail(input logic [7:0] v);
      return (v >= 8'h80) && (v <= 8'hBF);
   endfunction

endpackage

// File: rtl/core/utf8sd_front.sv
// Front end: takes bytes, tracks the sequence and assembles decoded events.
module utf8sd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] byte_in
   input  utf8sd_pkg::queue_status_type q_status,
   output utf8sd_pkg::front_out_type    front_out
);
   import utf8sd_pkg::*;

   logic [7:0] lead_ff, lead_in;
   logic [7:0] second_ff, second_in;
   logic [7:0] third_ff, third_in;
   logic [1:0] need_ff, need_in;
   logic [1:0] seen_ff, seen_in;

   logic       accept;
   logic [7:0] b;
   logic [2:0] seen_next;
   logic       ok3_rng;
   logic       ok4_rng;
   logic [CpWidth-1:0] cp2, cp3, cp4;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign seen_next  = {1'b0, seen_ff} + 3'd1;

   // Well-formed ranges of the second byte for three- and four-byte forms
   assign ok3_rng = ((lead_ff == 8'hE0) && (second_ff >= 8'hA0) && (second_ff <= 8'hBF)) ||
                    ((lead_ff == 8'hED) && (second_ff >= 8'h80) && (second_ff <= 8'h9F)) ||
                    ((lead_ff >= 8'hE1) && (lead_ff <= 8'hEC) && is_tail(second_ff)) ||
                    (((lead_ff == 8'hEE) || (lead_ff == 8'hEF)) && is_tail(second_ff));
   assign ok4_rng = ((lead_ff == 8'hF0) && (second_ff >= 8'h90) && (second_ff <= 8'hBF)) ||
                    ((lead_ff == 8'hF4) && (second_ff >= 8'h80) && (second_ff <= 8'h8F)) ||
                    ((lead_ff >= 8'hF1) && (lead_ff <= 8'hF3) && is_tail(second_ff));

   // Assemble code points for each sequence length
   assign cp2 = {10'd0, lead_ff[4:0], b[5:0]};
   assign cp3 = {5'd0, lead_ff[3:0], second_ff[5:0], b[5:0]};
   assign cp4 = {lead_ff[2:0], second_ff[5:0], third_ff[5:0], b[5:0]};

   // Classify the word and step the sequence tracker
   always_comb begin
      lead_in   = lead_ff;
      second_in = second_ff;
      third_in  = third_ff;
      need_in   = need_ff;
      seen_in   = seen_ff;
      front_out = '0;
      if (need_ff == 2'd0) begin
         priority if (b < 8'h80) begin
            front_out.push   = 1'b1;
            front_out.ev.cp  = {13'd0, b};
         end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
            need_in = 2'd1;
            lead_in = b;
            seen_in = 2'd0;
         end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
            need_in = 2'd2;
            lead_in = b;
            seen_in = 2'd0;
         end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
            need_in = 2'd3;
            lead_in = b;
            seen_in = 2'd0;
         end else begin
            front_out.push   = 1'b1;
            front_out.ev.bad = 1'b1;
         end
      end else if (seen_next >= {1'b0, need_ff}) begin
         // Last byte gathered: check the whole sequence
         front_out.push = 1'b1;
         unique case (need_ff)
            2'd1: begin
               front_out.ev.bad = !is_tail(b);
               front_out.ev.cp  = cp2;
            end
            2'd2: begin
               front_out.ev.bad = !(is_tail(b) && ok3_rng);
               front_out.ev.cp  = cp3;
            end
            default: begin
               front_out.ev.bad = !(is_tail(third_ff) && is_tail(b) && ok4_rng);
               front_out.ev.cp  = cp4;
            end
         endcase
         if (front_out.ev.bad) begin
            front_out.ev.cp = '0;
         end
         need_in = 2'd0;
         seen_in = 2'd0;
      end else begin
         if (seen_ff == 2'd0) begin
            second_in = b;
         end else begin
            third_in = b;
         end
         seen_in = seen_next[1:0];
      end
      if (!accept) begin
         front_out.push = 1'b0;
      end
   end

   // Hold sequence state, advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= 2'd0;
         seen_ff <= 2'd0;
      end else if (accept) begin
         need_ff <= need_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff   <= lead_in;
         second_ff <= second_in;
         third_ff  <= third_in;
      end
   end

endmodule

// File: rtl/core/utf8sd_queue.sv
// Short first-in first-out queue of decoded events between front and back.
module utf8sd_queue #(
   parameter int unsigned Depth = utf8sd_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  utf8sd_pkg::front_out_type     front_out,
   input  logic                          pop,
   output utf8sd_pkg::event_type         head,
   output utf8sd_pkg::queue_status_type  q_status
);
   import utf8sd_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   event_type           mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign q_status.full  = (count_ff == CntWidth'(Depth));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = front_out.push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed event
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= front_out.ev;
      end
   end

endmodule

// File: rtl/core/utf8sd_back.sv
// Back end: applies the error mode and drives the result output register.
module utf8sd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_data,
   input  utf8sd_pkg::event_type         head,
   input  utf8sd_pkg::queue_status_type  q_status,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [1:0]                    rsp_tuser    // [1:0] status
);
   import utf8sd_pkg::*;

   logic [1:0]         mode_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CpWidth-1:0] rsp_cp_ff, rsp_cp_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               drop;
   logic               load;

   assign csr_ready = 1'b1;

   // Hold the error mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_REPLACE;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   // Map the head event to a result, or drop it
   always_comb begin
      drop          = 1'b0;
      rsp_cp_in     = head.cp;
      rsp_status_in = STATUS_VALID;
      if (head.bad) begin
         unique case (mode_ff)
            MODE_REPORT: begin
               rsp_cp_in     = '0;
               rsp_status_in = STATUS_REPORTED;
            end
            MODE_REPLACE: begin
               rsp_cp_in     = REPLACEMENT_CP;
               rsp_status_in = STATUS_REPLACED;
            end
            default: begin
               drop = 1'b1;
            end
         endcase
      end
   end

   assign pop  = !q_status.empty && (!rsp_valid_ff || rsp_tready);
   assign load = pop && !drop;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_cp_ff     <= rsp_cp_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_cp_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder.
`include "utf8_stream_decoder_assert.svh"

// UTF-8 stream decoder. Takes one byte per word on req_ and returns decoded
// code points on rsp_, one result per complete sequence and at most one per
// byte. A byte is accepted every cycle while the event queue has room; the
// queue takes one push per cycle, which sets the rate at one byte per clock.
// A result reaches rsp_ through the event queue and then the output register.
// Lead bytes 0x80-0xC1 and 0xF5-0xFF fail at once; a multi-byte sequence is
// always taken to its announced length before it is checked. The csr_ register
// selects what a failure gives: 0 a status 1 result with code point 0, 1 (after
// reset) a status 2 result with 0xFFFD, 2 or 3 no result. Write it only
// while idle.
module utf8_stream_decoder #(
   parameter int unsigned QueueDepth = utf8sd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // [1:0] error_mode
);
   import utf8sd_pkg::*;

   front_out_type    front_out;
   queue_status_type q_status;
   event_type        head;
   logic             pop;

   utf8sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .front_out  (front_out)
   );

   utf8sd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .front_out (front_out),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   utf8sd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A full queue must stall the input side
   `UTF8SD_ASSERT_NOW(a_no_push_when_full, clock, reset, q_status.full, !front_out.push && !req_tready, "push into full queue")
   // An idle output register takes the queue head at once
   `UTF8SD_ASSERT_NOW(a_back_drains, clock, reset, !q_status.empty && !rsp_tvalid, pop, "back end left queue waiting")
   // A pushed event leaves the queue non-empty
   `UTF8SD_ASSERT_NEXT(a_push_fills, clock, reset, front_out.push, !q_status.empty, "pushed event lost")

endmodule

// File: tb/utf8_stream_decoder_tb.sv
// Self-checking testbench for the UTF-8 stream decoder with a byte-level decode predictor.
module utf8_stream_decoder_tb;
   import utf8sd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS  = 10;
   // Fourth mode code has no package name; it drops like MODE_DROP
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   typedef struct {
      logic [CpWidth-1:0] cp;
      status_type         st;
   } char_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_data;

   // Decoder state as predicted
   logic [1:0]  dec_mode   = MODE_REPLACE;
   logic [7:0]  dec_lead   = '0;
   logic [7:0]  dec_second = '0;
   logic [7:0]  dec_third  = '0;
   int          dec_need   = 0;
   int          dec_seen   = 0;

   char_result_type pending_chars[$];
   char_result_type head;

   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 59;
   int unsigned cycle_count   = 0;
   int unsigned bytes_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned mode_writes   = 0;
   int unsigned mismatch_count = 0;

   utf8_stream_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hold the run inside the cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stalled past %0d cycles, %0d results outstanding",
                  CYCLE_LIMIT, pending_chars.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Throttle the result side
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each accepted result word with the oldest predicted character
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: cp %h status %0d", rsp_tdata, rsp_tuser);
         end else begin
            head = pending_chars.pop_front();
            if (rsp_tdata !== {3'b000, head.cp} || rsp_tuser !== head.st) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected cp %h status %0d, got cp %h status %0d",
                           head.cp, head.st, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   function automatic logic is_cont(input logic [7:0] v);
      return (v >= 8'h80) && (v <= 8'hBF);
   endfunction

   function automatic logic [7:0] tail_byte();
      return 8'($urandom_range(8'hBF, 8'h80));
   endfunction

   task automatic push_char(input logic [CpWidth-1:0] cp, input status_type st);
      char_result_type r;
      r.cp = cp;
      r.st = st;
      pending_chars.push_back(r);
   endtask

   // A malformed sequence yields a result only in report and replace modes
   task automatic push_malformed();
      if (dec_mode == MODE_REPORT)
         push_char('0, STATUS_REPORTED);
      else if (dec_mode == MODE_REPLACE)
         push_char(REPLACEMENT_CP, STATUS_REPLACED);
   endtask

   // Check a gathered sequence whose final byte is last
   task automatic close_sequence(input logic [7:0] last);
      logic ok;
      case (dec_need)
         1: begin
            if (!is_cont(last))
               push_malformed();
            else
               push_char({10'd0, dec_lead[4:0], last[5:0]}, STATUS_VALID);
         end
         2: begin
            ok = (dec_lead == 8'hE0 && dec_second >= 8'hA0 && dec_second <= 8'hBF) ||
                 (dec_lead == 8'hED && dec_second >= 8'h80 && dec_second <= 8'h9F) ||
                 (dec_lead >= 8'hE1 && dec_lead <= 8'hEC && is_cont(dec_second)) ||
                 (dec_lead >= 8'hEE && dec_lead <= 8'hEF && is_cont(dec_second));
            if (!is_cont(last) || !ok)
               push_malformed();
            else
               push_char({5'd0, dec_lead[3:0], dec_second[5:0], last[5:0]}, STATUS_VALID);
         end
         default: begin
            ok = (dec_lead == 8'hF0 && dec_second >= 8'h90 && dec_second <= 8'hBF) ||
                 (dec_lead == 8'hF4 && dec_second >= 8'h80 && dec_second <= 8'h8F) ||
                 (dec_lead >= 8'hF1 && dec_lead <= 8'hF3 && is_cont(dec_second));
            if (!is_cont(dec_third) || !is_cont(last) || !ok)
               push_malformed();
            else
               push_char({dec_lead[2:0], dec_second[5:0], dec_third[5:0], last[5:0]},
                         STATUS_VALID);
         end
      endcase
   endtask

   // Advance the predicted decoder by one accepted byte
   task automatic decode_byte(input logic [7:0] b);
      if (dec_need == 0) begin
         if (b < 8'h80) begin
            push_char({13'd0, b}, STATUS_VALID);
         end else if (b >= 8'hC2 && b <= 8'hF4) begin
            dec_need = (b >= 8'hF0) ? 3 : (b >= 8'hE0) ? 2 : 1;
            dec_lead = b;
            dec_seen = 0;
         end else begin
            push_malformed();
         end
      end else if (dec_seen + 1 >= dec_need) begin
         close_sequence(b);
         dec_need = 0;
         dec_seen = 0;
      end else begin
         if (dec_seen == 0)
            dec_second = b;
         else
            dec_third = b;
         dec_seen++;
      end
   endtask

   // Offer one byte after a random gap and wait for the handshake
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      decode_byte(b);
   endtask

   task automatic send_list(input logic [7:0] seq[$]);
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   // Drop valid and hold until every predicted result has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_error_mode(input logic [1:0] m);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dec_mode = m;
      mode_writes++;
   endtask

   // Well-formed character of random length and content
   task automatic send_valid_char();
      logic [7:0] lead;
      case ($urandom_range(4, 1))
         1: send_byte(8'($urandom_range(8'h7F)));
         2: begin
            send_byte(8'($urandom_range(8'hDF, 8'hC2)));
            send_byte(tail_byte());
         end
         3: begin
            lead = 8'($urandom_range(8'hEF, 8'hE0));
            send_byte(lead);
            if (lead == 8'hE0)
               send_byte(8'($urandom_range(8'hBF, 8'hA0)));
            else if (lead == 8'hED)
               send_byte(8'($urandom_range(8'h9F, 8'h80)));
            else
               send_byte(tail_byte());
            send_byte(tail_byte());
         end
         default: begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            send_byte(lead);
            if (lead == 8'hF0)
               send_byte(8'($urandom_range(8'hBF, 8'h90)));
            else if (lead == 8'hF4)
               send_byte(8'($urandom_range(8'h8F, 8'h80)));
            else
               send_byte(tail_byte());
            send_byte(tail_byte());
            send_byte(tail_byte());
         end
      endcase
   endtask

   // Valid lead byte followed by loosely formed continuation bytes
   task automatic send_broken_seq();
      logic [7:0] lead;
      int         need;
      lead = 8'($urandom_range(8'hF4, 8'hC2));
      need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
      send_byte(lead);
      repeat (need) begin
         if ($urandom_range(3) == 0)
            send_byte(8'($urandom_range(255)));
         else
            send_byte(tail_byte());
      end
   endtask

   task automatic send_stream(input int unsigned n_bytes);
      int unsigned start;
      int unsigned pick;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 75)
            send_valid_char();
         else if (pick < 90)
            send_broken_seq();
         else
            send_byte(8'($urandom_range(255)));
      end
   endtask

   // Byte extremes, every length, range edges and bad bytes in reset mode
   task automatic test_directed_chars();
      logic [7:0] seq[$];
      seq = '{8'h00, 8'h7F, 8'h80, 8'hFF,
              8'hC2, 8'h80, 8'hDF, 8'hBF,
              8'hE0, 8'hA0, 8'h80,
              8'hED, 8'hA0, 8'h80,
              8'hF0, 8'h90, 8'h80, 8'h80,
              8'hF4, 8'h8F, 8'hBF, 8'hBF,
              8'hC2, 8'h41};
      send_list(seq);
   endtask

   // Bad lead and overlong sequence under the other error modes
   task automatic test_error_modes();
      logic [7:0] seq[$];
      seq = '{8'hC1, 8'hE0, 8'h9F, 8'h80};
      set_error_mode(MODE_REPORT);
      send_list(seq);
      set_error_mode(MODE_DROP);
      send_list(seq);
      set_error_mode(MODE_UNUSED);
      send_list(seq);
   endtask

   task automatic test_random_stream();
      send_idle_pct = 9;
      recv_idle_pct = 59;
      set_error_mode(MODE_REPORT);
      send_stream(180);
      set_error_mode(MODE_DROP);
      send_stream(180);

      send_idle_pct = 59;
      recv_idle_pct = 9;
      set_error_mode(MODE_UNUSED);
      send_stream(180);
      set_error_mode(MODE_REPLACE);
      send_stream(180);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_error_mode(MODE_REPORT);
      send_stream(180);
      set_error_mode(MODE_REPLACE);
      send_stream(180);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_chars();
      test_error_modes();
      test_random_stream();
      drain_results();

      $display("decoded %0d bytes into %0d results across %0d error-mode writes",
               bytes_sent, results_seen, mode_writes);
      $display("covered all sequence lengths, bad leads, bad tails and all four modes");
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_chars.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
